/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the frame receiver top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* design/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

    // payload store geometry
    localparam int PAYLOAD_DEPTH = 64;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
    localparam int LEN_CAP       = (PAYLOAD_DEPTH < 64) ? PAYLOAD_DEPTH : 64;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int FUNC_LIM_W = 9;
    localparam int LEN_LIM_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT   = 2'd3;

    // register reset values
    localparam logic [BYTE_W-1:0]     RST_HEADER_FIRST   = 8'hAA;
    localparam logic [BYTE_W-1:0]     RST_HEADER_SECOND  = 8'hAF;
    localparam logic [FUNC_LIM_W-1:0] RST_FUNCTION_LIMIT = 9'd241;
    localparam logic [LEN_LIM_W-1:0]  RST_LENGTH_LIMIT   = 7'd50;

    // controller to datapath commands
    typedef struct packed {
        logic sum_init;
        logic add_sum;
        logic hold_func;
        logic hold_len;
        logic wr_payload;
        logic rd_start;
        logic rd_next;
        logic load_good;
        logic load_bad;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic hdr1_match;
        logic hdr2_match;
        logic func_ok;
        logic len_ok;
        logic remaining_zero;
        logic remaining_one;
        logic sum_match;
        logic drain_last;
        logic out_free;
        logic out_taken;
    } status_t;

endpackage

`default_nettype wire

/* design/cfr_ram.sv */
// ----------------------------------------------------------------------------
// cfr_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/cfr_ctrl.sv */
// ----------------------------------------------------------------------------
// cfr_ctrl
// Frame parse and payload drain state machine.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire cfr_pkg::status_t status,
    output cfr_pkg::cmd_t        cmd
);

    localparam logic [2:0] ST_HDR1       = 3'd0;
    localparam logic [2:0] ST_HDR2       = 3'd1;
    localparam logic [2:0] ST_FUNC       = 3'd2;
    localparam logic [2:0] ST_LEN        = 3'd3;
    localparam logic [2:0] ST_PAYLOAD    = 3'd4;
    localparam logic [2:0] ST_CHECK      = 3'd5;
    localparam logic [2:0] ST_DRAIN_LD   = 3'd6;
    localparam logic [2:0] ST_DRAIN_WAIT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    // ready and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_HDR1:
            begin
                s_tready = 1'b1;
                if (accept && status.hdr1_match)
                begin
                    cmd.sum_init = 1'b1;
                    state_next   = ST_HDR2;
                end
            end
            ST_HDR2:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    if (status.hdr2_match)
                    begin
                        cmd.add_sum = 1'b1;
                        state_next  = ST_FUNC;
                    end
                    else
                    begin
                        state_next = ST_HDR1;
                    end
                end
            end
            ST_FUNC:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    if (status.func_ok)
                    begin
                        cmd.add_sum   = 1'b1;
                        cmd.hold_func = 1'b1;
                        state_next    = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_HDR1;
                    end
                end
            end
            ST_LEN:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    if (status.len_ok)
                    begin
                        cmd.add_sum  = 1'b1;
                        cmd.hold_len = 1'b1;
                        state_next   = ST_PAYLOAD;
                    end
                    else
                    begin
                        state_next = ST_HDR1;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    // a zero-length frame falls back to idle here
                    if (status.remaining_zero)
                    begin
                        state_next = ST_HDR1;
                    end
                    else
                    begin
                        cmd.add_sum    = 1'b1;
                        cmd.wr_payload = 1'b1;
                        if (status.remaining_one)
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                // checksum byte waits until the output register can take a result
                s_tready = status.out_free;
                if (accept)
                begin
                    if (status.sum_match)
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = ST_DRAIN_LD;
                    end
                    else
                    begin
                        cmd.load_bad = 1'b1;
                        state_next   = ST_HDR1;
                    end
                end
            end
            ST_DRAIN_LD:
            begin
                cmd.load_good = 1'b1;
                state_next    = status.drain_last ? ST_HDR1 : ST_DRAIN_WAIT;
            end
            ST_DRAIN_WAIT:
            begin
                if (status.out_taken)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = ST_DRAIN_LD;
                end
            end
            default:
            begin
                state_next = ST_HDR1;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HDR1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* design/cfr_datapath.sv */
// ----------------------------------------------------------------------------
// cfr_datapath
// Config registers, checksum, frame fields, payload store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr,
    input  wire logic [cfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cfr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [cfr_pkg::BYTE_W-1:0]       rx_byte,
    input  wire cfr_pkg::cmd_t                    cmd,
    output cfr_pkg::status_t                      status,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic [cfr_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    localparam int BW  = cfr_pkg::BYTE_W;
    localparam int LW  = cfr_pkg::LEN_W;
    localparam int AW  = cfr_pkg::ADDR_W;
    localparam int PADW = cfr_pkg::OUT_DATA_W - 2 * BW - 2 * LW;

    // config registers
    logic [BW-1:0]                    header_first_reg;
    logic [BW-1:0]                    header_second_reg;
    logic [cfr_pkg::FUNC_LIM_W-1:0]   function_limit_reg;
    logic [cfr_pkg::LEN_LIM_W-1:0]    length_limit_reg;
    logic [cfr_pkg::LEN_LIM_W-1:0]    length_limit_eff;

    // frame state
    logic [BW-1:0] sum_reg;
    logic [BW-1:0] sum_next;
    logic [BW-1:0] func_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] remaining_reg;
    logic [LW-1:0] remaining_next;
    logic [LW-1:0] wr_idx_reg;
    logic [LW-1:0] wr_idx_next;
    logic [LW-1:0] rd_idx_reg;
    logic [LW-1:0] rd_idx_next;

    // payload store read side
    logic          ram_rd_en;
    logic [LW-1:0] ram_rd_idx;
    logic [BW-1:0] ram_rd_data;

    // output register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_ok_reg;
    logic [BW-1:0] out_func_reg;
    logic [LW-1:0] out_len_reg;
    logic [LW-1:0] out_idx_reg;
    logic [BW-1:0] out_byte_reg;
    logic          out_last_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg   <= cfr_pkg::RST_HEADER_FIRST;
            header_second_reg  <= cfr_pkg::RST_HEADER_SECOND;
            function_limit_reg <= cfr_pkg::RST_FUNCTION_LIMIT;
            length_limit_reg   <= cfr_pkg::RST_LENGTH_LIMIT;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                cfr_pkg::REG_HEADER_FIRST:   header_first_reg   <= cfg_data[BW-1:0];
                cfr_pkg::REG_HEADER_SECOND:  header_second_reg  <= cfg_data[BW-1:0];
                cfr_pkg::REG_FUNCTION_LIMIT: function_limit_reg <= cfg_data;
                cfr_pkg::REG_LENGTH_LIMIT:
                    length_limit_reg <= cfg_data[cfr_pkg::LEN_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // length limit capped by the store size
    assign length_limit_eff =
        (length_limit_reg > cfr_pkg::LEN_LIM_W'(cfr_pkg::LEN_CAP))
        ? cfr_pkg::LEN_LIM_W'(cfr_pkg::LEN_CAP) : length_limit_reg;

    // byte checks
    always_comb
    begin
        status.hdr1_match     = (rx_byte == header_first_reg);
        status.hdr2_match     = (rx_byte == header_second_reg);
        status.func_ok        = ({1'b0, rx_byte} < function_limit_reg);
        status.len_ok         = (rx_byte < {1'b0, length_limit_eff});
        status.remaining_zero = (remaining_reg == '0);
        status.remaining_one  = (remaining_reg == LW'(1));
        status.sum_match      = (sum_reg == rx_byte);
        status.drain_last     = ((rd_idx_reg + LW'(1)) == len_reg);
        status.out_free       = !out_valid_reg || m_tready;
        status.out_taken      = out_valid_reg && m_tready;
    end

    // running checksum and counters
    always_comb
    begin
        sum_next       = sum_reg;
        remaining_next = remaining_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        if (cmd.sum_init)
        begin
            sum_next = rx_byte;
        end
        else if (cmd.add_sum)
        begin
            sum_next = sum_reg + rx_byte;
        end
        if (cmd.hold_len)
        begin
            remaining_next = rx_byte[LW-1:0];
            wr_idx_next    = '0;
        end
        else if (cmd.wr_payload)
        begin
            remaining_next = remaining_reg - LW'(1);
            wr_idx_next    = wr_idx_reg + LW'(1);
        end
        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_idx_next = rd_idx_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            func_reg      <= '0;
            len_reg       <= '0;
            remaining_reg <= '0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            sum_reg       <= sum_next;
            remaining_reg <= remaining_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            if (cmd.hold_func)
            begin
                func_reg <= rx_byte;
            end
            if (cmd.hold_len)
            begin
                len_reg <= rx_byte[LW-1:0];
            end
        end
    end

    // payload store, read address is the next value of the index register
    assign ram_rd_en  = cmd.rd_start || cmd.rd_next;
    assign ram_rd_idx = rd_idx_next;

    cfr_ram #(
        .DATA_W (BW),
        .DEPTH  (cfr_pkg::PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_payload),
        .wr_addr (AW'(wr_idx_reg)),
        .wr_data (rx_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (AW'(ram_rd_idx)),
        .rd_data (ram_rd_data)
    );

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_good || cmd.load_bad)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, error result carries zero index and byte
    always_ff @(posedge clk)
    begin
        if (cmd.load_good || cmd.load_bad)
        begin
            out_ok_reg   <= cmd.load_good;
            out_func_reg <= func_reg;
            out_len_reg  <= len_reg;
            out_idx_reg  <= cmd.load_good ? rd_idx_reg : '0;
            out_byte_reg <= cmd.load_good ? ram_rd_data : '0;
            out_last_reg <= cmd.load_good ? status.drain_last : 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PADW{1'b0}}, out_byte_reg, out_idx_reg, out_len_reg, out_func_reg};
    assign m_tuser  = out_ok_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* design/checksummed_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_top
// Serial byte frame parser with additive checksum and payload drain.
// ----------------------------------------------------------------------------
// Bytes enter on the s_ stream one per request. A frame is header_first,
// header_second, function code, length L, L payload bytes and an 8-bit
// wrapping sum of all earlier frame bytes. Results leave on the m_ stream:
// a good frame gives L requests (tuser set, tlast on the final one), a bad
// checksum gives one request with tuser clear and tlast set.
// Parse bytes are taken one per cycle. The checksum byte is held off until
// the output register is free. An error result appears in the cycle after
// the checksum byte; each result of a good frame takes a payload RAM read
// then an output register load, the next read waiting until the previous
// result is taken. No input is taken during the drain; the parser reopens
// once the last result is loaded. A stalled receiver simply holds the
// output register and the drain. The cfg channel is always ready; the user
// is to write only while idle, which the block itself does not enforce.
// Reset clears the parser and restores the register defaults; the payload
// RAM needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module checksummed_frame_receiver_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // config write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cfr_pkg::CFG_DATA_W-1:0] cfg_data,
    // received bytes
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [cfr_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    // results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] function_code, [13:8] payload_length, [19:14] byte_index,
    // [27:20] payload_byte, [31:28] zero
    output logic [cfr_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser,   // [0] frame_ok
    output logic                                m_tlast    // last
);

    cfr_pkg::cmd_t    cmd;
    cfr_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // control
    cfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    cfr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // checks
    `ASSERT_ALWAYS(a_err_result_shape, clk, rst_n, (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[27:14] == 14'd0)), "error result must be last with zero index and byte")
    `ASSERT_NEVER(a_wr_rd_overlap, clk, rst_n, cmd.wr_payload && (cmd.rd_start || cmd.rd_next), "payload write during drain read")
    `ASSERT_ALWAYS(a_load_when_free, clk, rst_n, (cmd.load_good || cmd.load_bad) |-> status.out_free, "output register overwritten while pending")

endmodule

`default_nettype wire

/* test/checksummed_frame_receiver_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_top_tb
// Feeds framed and broken byte streams into the frame receiver, under several
// register settings and with random stalls on both streams. A local frame
// parser predicts every result, and each result request is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------

module checksummed_frame_receiver_top_tb;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int FLUSH_BYTES   = 66;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR2,
        PH_FUNC,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK
    } parse_phase_t;

    typedef struct packed {
        logic                       frame_ok;
        logic [cfr_pkg::BYTE_W-1:0] function_code;
        logic [cfr_pkg::LEN_W-1:0]  payload_length;
        logic [cfr_pkg::LEN_W-1:0]  byte_index;
        logic [cfr_pkg::BYTE_W-1:0] payload_byte;
        logic                       last;
    } frame_output_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index = cfr_pkg::REG_HEADER_FIRST;
    logic [cfr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [cfr_pkg::BYTE_W-1:0]     s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [cfr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    // stimulus and checking bookkeeping
    logic [cfr_pkg::BYTE_W-1:0] bytes_to_send [$];
    frame_output_t     outputs_due [$];
    frame_output_t     oldest_due;
    int                items_queued     = 0;
    int                mismatch_count   = 0;
    int                quiet_cycles     = 0;
    int                hold_cycles_left = 0;
    int                send_idle_pct    = 32;
    int                recv_idle_pct    = 60;
    logic              send_pause       = 1'b0;
    logic              hold_request     = 1'b0;

    // local copy of the registers
    logic [cfr_pkg::BYTE_W-1:0]     hdr_first_reg  = cfr_pkg::RST_HEADER_FIRST;
    logic [cfr_pkg::BYTE_W-1:0]     hdr_second_reg = cfr_pkg::RST_HEADER_SECOND;
    logic [cfr_pkg::FUNC_LIM_W-1:0] func_limit_reg = cfr_pkg::RST_FUNCTION_LIMIT;
    logic [cfr_pkg::LEN_LIM_W-1:0]  len_limit_reg  = cfr_pkg::RST_LENGTH_LIMIT;

    // local copy of the parser state
    parse_phase_t               phase_now     = PH_IDLE;
    logic [cfr_pkg::LEN_W-1:0]  left_to_store = '0;
    logic [cfr_pkg::LEN_W-1:0]  store_ptr     = '0;
    logic [cfr_pkg::LEN_W-1:0]  held_len      = '0;
    logic [cfr_pkg::BYTE_W-1:0] held_func     = '0;
    logic [cfr_pkg::BYTE_W-1:0] sum_acc       = '0;
    logic [cfr_pkg::BYTE_W-1:0] payload_mem [cfr_pkg::PAYLOAD_DEPTH];

    checksummed_frame_receiver_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // largest length byte that the parser takes, plus one
    function automatic logic [cfr_pkg::LEN_LIM_W-1:0] length_cap();
        logic [cfr_pkg::LEN_LIM_W-1:0] cap;
        cap = cfr_pkg::LEN_LIM_W'(cfr_pkg::LEN_CAP);
        if (len_limit_reg < cap)
            cap = len_limit_reg;
        return cap;
    endfunction

    // advance the frame parser by one received byte, queue its outputs
    task automatic parse_rx_byte(input logic [cfr_pkg::BYTE_W-1:0] b);
        frame_output_t beat;
        beat.function_code  = held_func;
        beat.payload_length = held_len;
        case (phase_now)
            PH_IDLE:
            begin
                if (b == hdr_first_reg)
                begin
                    phase_now = PH_HDR2;
                    sum_acc   = b;
                end
            end
            PH_HDR2:
            begin
                if (b == hdr_second_reg)
                begin
                    phase_now = PH_FUNC;
                    sum_acc   = sum_acc + b;
                end
                else
                    phase_now = PH_IDLE;
            end
            PH_FUNC:
            begin
                if ({1'b0, b} < func_limit_reg)
                begin
                    phase_now = PH_LEN;
                    held_func = b;
                    sum_acc   = sum_acc + b;
                end
                else
                    phase_now = PH_IDLE;
            end
            PH_LEN:
            begin
                if ({1'b0, b} < length_cap())
                begin
                    phase_now     = PH_PAYLOAD;
                    held_len      = b[cfr_pkg::LEN_W-1:0];
                    left_to_store = b[cfr_pkg::LEN_W-1:0];
                    store_ptr     = '0;
                    sum_acc       = sum_acc + b;
                end
                else
                    phase_now = PH_IDLE;
            end
            PH_PAYLOAD:
            begin
                if (left_to_store != 0)
                begin
                    payload_mem[store_ptr] = b;
                    store_ptr     = store_ptr + 1'b1;
                    left_to_store = left_to_store - 1'b1;
                    sum_acc       = sum_acc + b;
                    if (left_to_store == 0)
                        phase_now = PH_CHECK;
                end
                else
                    phase_now = PH_IDLE;
            end
            PH_CHECK:
            begin
                phase_now = PH_IDLE;
                if (sum_acc == b)
                begin
                    // good frame: one output per stored payload byte
                    for (int i = 0; i < held_len; i++)
                    begin
                        beat.frame_ok     = 1'b1;
                        beat.byte_index   = i[cfr_pkg::LEN_W-1:0];
                        beat.payload_byte = payload_mem[i];
                        beat.last         = (i + 1 == held_len);
                        outputs_due.push_back(beat);
                    end
                end
                else
                begin
                    beat.frame_ok     = 1'b0;
                    beat.byte_index   = '0;
                    beat.payload_byte = '0;
                    beat.last         = 1'b1;
                    outputs_due.push_back(beat);
                end
            end
            default:
                phase_now = PH_IDLE;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (bytes_to_send.size() != 0 && !send_pause &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= bytes_to_send.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (outputs_due.size() == 0)
                begin
                    $error("result request with none predicted: tdata 0x%0h tuser %0b",
                           m_tdata, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    oldest_due = outputs_due.pop_front();
                    check_field("frame_ok", oldest_due.frame_ok, m_tuser);
                    check_field("function_code", oldest_due.function_code, m_tdata[7:0]);
                    check_field("payload_length", oldest_due.payload_length, m_tdata[13:8]);
                    check_field("byte_index", oldest_due.byte_index, m_tdata[19:14]);
                    check_field("payload_byte", oldest_due.payload_byte, m_tdata[27:20]);
                    check_field("last", oldest_due.last, m_tlast);
                end
            end
            if (hold_cycles_left > 0)
            begin
                hold_cycles_left = hold_cycles_left - 1;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_cycles_left = LONG_HOLD;
                hold_request <= 1'b0;
                m_tready     <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // register copy follows accepted writes
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cfr_pkg::REG_HEADER_FIRST:
                    hdr_first_reg  <= cfg_data[cfr_pkg::BYTE_W-1:0];
                cfr_pkg::REG_HEADER_SECOND:
                    hdr_second_reg <= cfg_data[cfr_pkg::BYTE_W-1:0];
                cfr_pkg::REG_FUNCTION_LIMIT:
                    func_limit_reg <= cfg_data[cfr_pkg::FUNC_LIM_W-1:0];
                cfr_pkg::REG_LENGTH_LIMIT:
                    len_limit_reg  <= cfg_data[cfr_pkg::LEN_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // watchdog on cycles without any request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic [cfr_pkg::BYTE_W-1:0] b);
        bytes_to_send.push_back(b);
        items_queued++;
    endtask

    // whole frame from the current headers; fill < 0 means random payload
    task automatic push_frame(input logic [cfr_pkg::BYTE_W-1:0] func,
                              input logic [cfr_pkg::LEN_W-1:0] len,
                              input bit corrupt, input int fill);
        logic [cfr_pkg::BYTE_W-1:0] sum;
        logic [cfr_pkg::BYTE_W-1:0] pb;
        sum = hdr_first_reg;
        sum = sum + hdr_second_reg;
        sum = sum + func;
        sum = sum + {2'b00, len};
        push_byte(hdr_first_reg);
        push_byte(hdr_second_reg);
        push_byte(func);
        push_byte({2'b00, len});
        for (int k = 0; k < len; k++)
        begin
            pb  = (fill < 0) ? $urandom_range(255) : fill;
            sum = sum + pb;
            push_byte(pb);
        end
        if (corrupt)
        begin
            pb = $urandom_range(255, 1);
            push_byte(sum + pb);
        end
        else
            push_byte(sum);
    endtask

    // mostly good frames, some bad checksums, broken frames and noise
    task automatic push_random_traffic(input int count);
        int                            stop;
        logic [cfr_pkg::LEN_LIM_W-1:0] cap;
        logic [cfr_pkg::BYTE_W-1:0]    func;
        logic [cfr_pkg::LEN_W-1:0]     len;
        logic [cfr_pkg::BYTE_W-1:0]    junk;
        int                            pick;
        stop = items_queued + count;
        while (items_queued < stop)
        begin
            cap  = length_cap();
            func = (func_limit_reg == 0) ? $urandom_range(255) : $urandom_range(func_limit_reg - 1, 0);
            if ($urandom_range(11) == 0)
                len = $urandom_range(cap - 1, 0);
            else
                len = $urandom_range((cap > 8) ? 7 : cap - 1, 0);
            pick = $urandom_range(9);
            if (pick <= 6)
                push_frame(func, len, 1'b0, -1);
            else if (pick == 7)
                push_frame(func, len, 1'b1, -1);
            else if (pick == 8)
            begin
                push_byte(hdr_first_reg);
                junk = $urandom_range(255, 1);
                case ($urandom_range(3))
                    0: push_byte(hdr_second_reg ^ junk);
                    1:
                    begin
                        push_byte(hdr_second_reg);
                        if (func_limit_reg <= 255)
                            push_byte($urandom_range(255, func_limit_reg));
                    end
                    2:
                    begin
                        push_byte(hdr_second_reg);
                        push_byte(func);
                        push_byte($urandom_range(255, cap));
                    end
                    default:
                    begin
                        // truncated frame, later bytes fill it up
                        push_byte(hdr_second_reg);
                        push_byte(func);
                        push_byte({2'b00, len});
                        for (int k = 0; k + 1 < len; k++)
                            push_byte($urandom_range(255));
                    end
                endcase
            end
            else
                push_byte($urandom_range(255));
        end
    endtask

    // filler bytes that match neither header, so the parser ends up idle
    task automatic push_flush();
        logic [cfr_pkg::BYTE_W-1:0] filler;
        filler = 8'h40;
        while (filler == hdr_first_reg || filler == hdr_second_reg)
            filler = filler + 1'b1;
        repeat (FLUSH_BYTES) bytes_to_send.push_back(filler);
    endtask

    // wait until every byte is taken and every predicted result has come
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (bytes_to_send.size() != 0 || s_tvalid || outputs_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [cfr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [cfr_pkg::CFG_DATA_W-1:0] val,
                                  input bit more);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [cfr_pkg::CFG_DATA_W-1:0] first,
                                  input logic [cfr_pkg::CFG_DATA_W-1:0] second,
                                  input logic [cfr_pkg::CFG_DATA_W-1:0] func_lim,
                                  input logic [cfr_pkg::CFG_DATA_W-1:0] len_lim);
        write_register(cfr_pkg::REG_HEADER_FIRST, first, 1'b1);
        write_register(cfr_pkg::REG_HEADER_SECOND, second, 1'b1);
        write_register(cfr_pkg::REG_FUNCTION_LIMIT, func_lim, 1'b1);
        write_register(cfr_pkg::REG_LENGTH_LIMIT, len_lim, 1'b0);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset settings
        push_frame(8'h00, 6'd1, 1'b0, 0);
        push_frame(cfr_pkg::RST_FUNCTION_LIMIT - 1'b1, 6'd2, 1'b1, 255);
        // zero length never completes and swallows the next header byte
        push_byte(hdr_first_reg);
        push_byte(hdr_second_reg);
        push_byte(8'h05);
        push_byte(8'h00);
        push_byte(hdr_first_reg);
        // function code equal to the limit
        push_byte(hdr_first_reg);
        push_byte(hdr_second_reg);
        push_byte(cfr_pkg::RST_FUNCTION_LIMIT[cfr_pkg::BYTE_W-1:0]);
        // wrong second header byte
        push_byte(hdr_first_reg);
        push_byte(8'h00);
        // length equal to the limit
        push_byte(hdr_first_reg);
        push_byte(hdr_second_reg);
        push_byte(8'h01);
        push_byte({1'b0, cfr_pkg::RST_LENGTH_LIMIT});
        push_random_traffic(30);
        push_flush();
        wait_quiet();

        // widest limits, long receiver hold over a full-length frame
        send_idle_pct <= 60;
        recv_idle_pct <= 32;
        apply_settings(9'h000, 9'h0FF, 9'h100, 9'd64);
        hold_request <= 1'b1;
        push_frame($urandom_range(255), 6'd63, 1'b0, -1);
        push_random_traffic(30);
        push_flush();
        wait_quiet();

        // narrowest limits: nothing gets past the function code
        apply_settings(9'h0FF, 9'h000, 9'h000, 9'd1);
        push_random_traffic(10);
        push_flush();
        wait_quiet();

        // only zero-length frames pass the length check
        apply_settings($urandom_range(255), $urandom_range(255), 9'h001, 9'd1);
        push_random_traffic(10);
        push_flush();
        wait_quiet();

        // random settings, no idling, one sender pause until all results drain
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        apply_settings($urandom_range(255), $urandom_range(255), $urandom_range(256, 16),
                       $urandom_range(64, 2));
        push_random_traffic(30);
        do
            @(negedge clk);
        while (bytes_to_send.size() > 10);
        @(posedge clk);
        send_pause <= 1'b1;
        do
            @(negedge clk);
        while (s_tvalid || outputs_due.size() != 0);
        @(posedge clk);
        send_pause <= 1'b0;
        push_random_traffic(20);
        wait_quiet();

        if (mismatch_count == 0 && outputs_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
